/* rtl/core/mbce_pkg.sv */
// Shared types, constants and mask tables for the monochrome colour expansion blitter.
// No dependencies; used by every module of the block.
package mbce_pkg;

    localparam int MAX_ROW_BYTES_DEF = 32;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 32;
    localparam int ADDR_W            = 32;
    localparam int COLOUR_W          = 32;
    localparam int SIZE_W            = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DST_BASE        = 3'd0,
        CFG_DST_ROW_STRIDE  = 3'd1,
        CFG_FIRST_BIT       = 3'd2,
        CFG_END_BIT_POS     = 3'd3,
        CFG_ROW_COUNT       = 3'd4,
        CFG_BYTES_PER_PIXEL = 3'd5,
        CFG_FILL_COLOUR     = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]          mask;
        logic [ADDR_W-1:0]   addr;
        logic [COLOUR_W-1:0] colour;
        logic [SIZE_W-1:0]   size;
    } work_item_t;

    function automatic logic [7:0] head_clip(input logic [3:0] first_bit);
        logic [7:0] m;
        case (first_bit)
            4'd0:    m = 8'hff;
            4'd1:    m = 8'h7f;
            4'd2:    m = 8'h3f;
            4'd3:    m = 8'h1f;
            4'd4:    m = 8'h0f;
            4'd5:    m = 8'h07;
            4'd6:    m = 8'h03;
            4'd7:    m = 8'h01;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] tail_clip(input logic [2:0] end_bit);
        logic [7:0] m;
        case (end_bit)
            3'd0:    m = 8'h00;
            3'd1:    m = 8'h80;
            3'd2:    m = 8'hc0;
            3'd3:    m = 8'he0;
            3'd4:    m = 8'hf0;
            3'd5:    m = 8'hf8;
            3'd6:    m = 8'hfc;
            default: m = 8'hfe;
        endcase
        return m;
    endfunction

endpackage

/* rtl/core/mono_bitmap_colour_expand.sv */
// Top level of the monochrome colour expansion blitter.
// Depends on mbce_pkg, mbce_front and mbce_expand.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------------------
//   input    | in_valid / in_stall   | src_bits
//   output   | out_valid / out_stall | write_addr, write_colour, write_size, last_of_byte
//   config   | cfg_write             | cfg_index, cfg_data
//
// One pixel write leaves per cycle while the output is not stalled; the expander's work
// register holds the masked byte. The input stalls until the last write of a word after
// masking is emitted, so a word with no writes does not hold it up.
// The next word enters in the cycle of the last write.
// Output stall freezes the output register and with it the expander.
// Reset (rst_n, asynchronous) clears config to defaults, positions, and the valid flags.
module mono_bitmap_colour_expand #(
    parameter int MAX_ROW_BYTES = mbce_pkg::MAX_ROW_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [mbce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mbce_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       src_bits,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mbce_pkg::ADDR_W-1:0]      write_addr,
    output logic [mbce_pkg::COLOUR_W-1:0]    write_colour,
    output logic [mbce_pkg::SIZE_W-1:0]      write_size,
    output logic                             last_of_byte
);

    mbce_pkg::work_item_t item;
    logic                 take;
    logic                 accept;

    assign in_stall = !take;
    assign accept   = in_valid && take;

    mbce_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .src_bits  (src_bits),
        .item      (item)
    );

    mbce_expand u_expand (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .in_valid     (in_valid),
        .take         (take),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .write_addr   (write_addr),
        .write_colour (write_colour),
        .write_size   (write_size),
        .last_of_byte (last_of_byte)
    );

endmodule

/* rtl/core/mbce_front.sv */
// Configuration registers, row and byte position tracking, and source byte masking.
// Depends on mbce_pkg; feeds one work item per accepted word to mbce_expand.
module mbce_front #(
    parameter int MAX_ROW_BYTES = mbce_pkg::MAX_ROW_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [mbce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mbce_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             accept,
    input  logic [7:0]                       src_bits,
    output mbce_pkg::work_item_t             item
);

    localparam int BW = $clog2(MAX_ROW_BYTES + 1);
    localparam int CW = (BW > 5) ? BW : 5;
    localparam int OW = BW + 3;

    logic [31:0] dst_base_reg;
    logic [15:0] dst_row_stride_reg;
    logic [3:0]  first_bit_reg;
    logic [7:0]  end_bit_pos_reg;
    logic [15:0] row_count_reg;
    logic [2:0]  bytes_per_pixel_reg;
    logic [31:0] fill_colour_reg;

    logic [BW-1:0] byte_in_row_reg, byte_in_row_next;
    logic [15:0]   row_index_reg, row_index_next;
    logic [31:0]   row_start_reg, row_start_next;

    logic          cfg_hit;
    logic [31:0]   restart_base;
    logic          active;
    logic          size_ok;
    logic [3:0]    sb;
    logic [CW-1:0] byte_pos;
    logic [CW-1:0] end_byte;
    logic [CW-1:0] last_byte;
    logic          is_first;
    logic          is_end;
    logic          is_last;
    logic [7:0]    masked;
    logic [OW-1:0] byte_off;
    logic [31:0]   colour;

    always_comb
    begin
        case (cfg_index)
            mbce_pkg::CFG_DST_BASE,
            mbce_pkg::CFG_DST_ROW_STRIDE,
            mbce_pkg::CFG_FIRST_BIT,
            mbce_pkg::CFG_END_BIT_POS,
            mbce_pkg::CFG_ROW_COUNT,
            mbce_pkg::CFG_BYTES_PER_PIXEL,
            mbce_pkg::CFG_FILL_COLOUR: cfg_hit = cfg_write;
            default:                   cfg_hit = 1'b0;
        endcase
    end

    assign restart_base = (cfg_index == mbce_pkg::CFG_DST_BASE) ? cfg_data : dst_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_base_reg        <= '0;
            dst_row_stride_reg  <= '0;
            first_bit_reg       <= '0;
            end_bit_pos_reg     <= '0;
            row_count_reg       <= '0;
            bytes_per_pixel_reg <= 3'd1;
            fill_colour_reg     <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mbce_pkg::CFG_DST_BASE:        dst_base_reg        <= cfg_data;
                mbce_pkg::CFG_DST_ROW_STRIDE:  dst_row_stride_reg  <= cfg_data[15:0];
                mbce_pkg::CFG_FIRST_BIT:       first_bit_reg       <= cfg_data[3:0];
                mbce_pkg::CFG_END_BIT_POS:     end_bit_pos_reg     <= cfg_data[7:0];
                mbce_pkg::CFG_ROW_COUNT:       row_count_reg       <= cfg_data[15:0];
                mbce_pkg::CFG_BYTES_PER_PIXEL: bytes_per_pixel_reg <= cfg_data[2:0];
                mbce_pkg::CFG_FILL_COLOUR:     fill_colour_reg     <= cfg_data;
                default:                       ;
            endcase
        end
    end

    assign active    = row_index_reg < row_count_reg;
    assign size_ok   = (bytes_per_pixel_reg >= 3'd1) && (bytes_per_pixel_reg <= 3'd4);
    assign sb        = (first_bit_reg > 4'd8) ? 4'd8 : first_bit_reg;
    assign byte_pos  = CW'(byte_in_row_reg);
    assign end_byte  = CW'(end_bit_pos_reg[7:3]);
    assign last_byte = (end_byte >= CW'(MAX_ROW_BYTES)) ? CW'(MAX_ROW_BYTES - 1) : end_byte;
    assign is_first  = byte_in_row_reg == '0;
    assign is_end    = byte_pos == end_byte;
    assign is_last   = byte_pos == last_byte;

    always_comb
    begin
        masked = src_bits;
        if (is_first)
        begin
            masked = masked & mbce_pkg::head_clip(sb);
        end
        if (is_end)
        begin
            masked = masked & mbce_pkg::tail_clip(end_bit_pos_reg[2:0]);
        end
    end

    always_comb
    begin
        case (bytes_per_pixel_reg)
            3'd1:    colour = {24'd0, fill_colour_reg[7:0]};
            3'd2:    colour = {16'd0, fill_colour_reg[15:0]};
            3'd3:    colour = {8'd0, fill_colour_reg[23:0]};
            default: colour = fill_colour_reg;
        endcase
    end

    assign byte_off = OW'(byte_in_row_reg) * OW'(bytes_per_pixel_reg);

    assign item.mask   = (active && size_ok) ? masked : 8'd0;
    assign item.addr   = row_start_reg + 32'({byte_off, 3'b000});
    assign item.colour = colour;
    assign item.size   = bytes_per_pixel_reg;

    always_comb
    begin
        byte_in_row_next = byte_in_row_reg;
        row_index_next   = row_index_reg;
        row_start_next   = row_start_reg;
        if (cfg_hit)
        begin
            byte_in_row_next = '0;
            row_index_next   = '0;
            row_start_next   = restart_base;
        end
        else if (accept && active)
        begin
            if (is_last)
            begin
                byte_in_row_next = '0;
                row_index_next   = row_index_reg + 16'd1;
                row_start_next   = row_start_reg + 32'(dst_row_stride_reg);
            end
            else
            begin
                byte_in_row_next = byte_in_row_reg + BW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_in_row_reg <= '0;
            row_index_reg   <= '0;
            row_start_reg   <= '0;
        end
        else
        begin
            byte_in_row_reg <= byte_in_row_next;
            row_index_reg   <= row_index_next;
            row_start_reg   <= row_start_next;
        end
    end

endmodule

/* rtl/core/mbce_expand.sv */
// Work register and output register: emits one pixel write per set mask bit, MSB first.
// Depends on mbce_pkg; takes work items from mbce_front.
module mbce_expand (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mbce_pkg::work_item_t            item,
    input  logic                            in_valid,
    output logic                            take,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic [mbce_pkg::ADDR_W-1:0]     write_addr,
    output logic [mbce_pkg::COLOUR_W-1:0]   write_colour,
    output logic [mbce_pkg::SIZE_W-1:0]     write_size,
    output logic                            last_of_byte
);

    logic [7:0]                      mask_reg, mask_next;
    logic [mbce_pkg::ADDR_W-1:0]     addr_reg;
    logic [mbce_pkg::COLOUR_W-1:0]   colour_reg;
    logic [mbce_pkg::SIZE_W-1:0]     size_reg;

    logic                            out_valid_reg, out_valid_next;
    logic [mbce_pkg::ADDR_W-1:0]     out_addr_reg;
    logic [mbce_pkg::COLOUR_W-1:0]   out_colour_reg;
    logic [mbce_pkg::SIZE_W-1:0]     out_size_reg;
    logic                            out_last_reg;

    logic       busy;
    logic       out_free;
    logic       emit;
    logic       load;
    logic [2:0] pick;
    logic [7:0] pick_hot;
    logic [7:0] remain;
    logic [4:0] pix_off;

    // leading set bit, MSB is pixel 0
    always_comb
    begin
        pick     = 3'd0;
        pick_hot = 8'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (mask_reg[i])
            begin
                pick     = 3'(7 - i);
                pick_hot = 8'(1 << i);
            end
        end
    end

    assign busy     = mask_reg != 8'd0;
    assign out_free = !out_valid_reg || !out_stall;
    assign remain   = mask_reg & ~pick_hot;
    assign emit     = busy && out_free;
    assign take     = !busy || (emit && (remain == 8'd0));
    assign load     = in_valid && take;
    assign pix_off  = 5'(pick) * 5'(size_reg);

    always_comb
    begin
        mask_next = mask_reg;
        if (load)
        begin
            mask_next = item.mask;
        end
        else if (emit)
        begin
            mask_next = remain;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr_reg   <= item.addr;
            colour_reg <= item.colour;
            size_reg   <= item.size;
        end
        if (emit)
        begin
            out_addr_reg   <= addr_reg + 32'(pix_off);
            out_colour_reg <= colour_reg;
            out_size_reg   <= size_reg;
            out_last_reg   <= remain == 8'd0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_addr   = out_addr_reg;
    assign write_colour = out_colour_reg;
    assign write_size   = out_size_reg;
    assign last_of_byte = out_last_reg;

endmodule

/* rtl/core/mbce_checker.sv */
// Port-level checks on the colour expansion blitter's output channel.
// Depends on mbce_pkg; bound to mono_bitmap_colour_expand below.
module mbce_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [mbce_pkg::ADDR_W-1:0]    write_addr,
    input logic [mbce_pkg::COLOUR_W-1:0]  write_colour,
    input logic [mbce_pkg::SIZE_W-1:0]    write_size,
    input logic                           last_of_byte
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(write_addr) && $stable(write_colour)
            && $stable(write_size) && $stable(last_of_byte))
        else $error("stalled output word changed");

    a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (write_size >= 3'd1) && (write_size <= 3'd4))
        else $error("pixel write size out of range");

    a_colour_trim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((write_size == 3'd1) && (write_colour[31:8] == 24'd0))
            || ((write_size == 3'd2) && (write_colour[31:16] == 16'd0))
            || ((write_size == 3'd3) && (write_colour[31:24] == 8'd0))
            || (write_size == 3'd4))
        else $error("colour bytes beyond pixel size not zero");

endmodule

bind mono_bitmap_colour_expand mbce_checker u_mbce_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .write_addr   (write_addr),
    .write_colour (write_colour),
    .write_size   (write_size),
    .last_of_byte (last_of_byte)
);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for mono_bitmap_colour_expand: directed and random blits.
// Depends on mbce_pkg and the block's RTL; predicts every pixel write in-line.
module testbench;

    localparam int           ROW_BYTES_LIMIT = mbce_pkg::MAX_ROW_BYTES_DEF;
    localparam int           SETTLE_CYCLES   = 16;
    localparam logic [2:0]   CFG_SPARE_INDEX = 3'd7;

    typedef struct packed {
        logic [mbce_pkg::ADDR_W-1:0]   addr;
        logic [mbce_pkg::COLOUR_W-1:0] colour;
        logic [mbce_pkg::SIZE_W-1:0]   size;
        logic                          last;
    } pixel_write_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_write;
    logic [mbce_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mbce_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic [7:0]                      src_bits;
    logic                            out_valid;
    logic                            out_stall;
    logic [mbce_pkg::ADDR_W-1:0]     write_addr;
    logic [mbce_pkg::COLOUR_W-1:0]   write_colour;
    logic [mbce_pkg::SIZE_W-1:0]     write_size;
    logic                            last_of_byte;

    // register shadow and blit position
    logic [31:0] reg_base;
    logic [15:0] reg_stride;
    logic [3:0]  reg_first_bit;
    logic [7:0]  reg_end_bit;
    logic [15:0] reg_rows;
    logic [2:0]  reg_bpp;
    logic [31:0] reg_colour;
    logic [5:0]  byte_pos;
    logic [15:0] rows_done;
    logic [31:0] row_addr;

    pixel_write_t pending_writes[$];
    int unsigned  fail_count;
    int unsigned  src_idle_pct;
    int unsigned  sink_stall_pct;
    int unsigned  hold_request;
    int unsigned  hold_left;

    mono_bitmap_colour_expand DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .src_bits     (src_bits),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .write_addr   (write_addr),
        .write_colour (write_colour),
        .write_size   (write_size),
        .last_of_byte (last_of_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic restart_blit();
        byte_pos  = '0;
        rows_done = '0;
        row_addr  = reg_base;
    endtask

    task automatic apply_reg(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            mbce_pkg::CFG_DST_BASE:        reg_base      = data;
            mbce_pkg::CFG_DST_ROW_STRIDE:  reg_stride    = data[15:0];
            mbce_pkg::CFG_FIRST_BIT:       reg_first_bit = data[3:0];
            mbce_pkg::CFG_END_BIT_POS:     reg_end_bit   = data[7:0];
            mbce_pkg::CFG_ROW_COUNT:       reg_rows      = data[15:0];
            mbce_pkg::CFG_BYTES_PER_PIXEL: reg_bpp       = data[2:0];
            mbce_pkg::CFG_FILL_COLOUR:     reg_colour    = data;
            default:                       return;
        endcase
        restart_blit();
    endtask

    // expected pixel writes for one accepted source word
    task automatic expand_word(input logic [7:0] src);
        logic [7:0]   bits;
        logic [7:0]   rest;
        logic [15:0]  tail_mask;
        logic [3:0]   lead;
        logic [31:0]  colour;
        int unsigned  tail_byte;
        int unsigned  span;
        pixel_write_t w;
        if (rows_done >= reg_rows)
            return;
        tail_byte = 32'(reg_end_bit) >> 3;
        span      = (tail_byte + 1 > ROW_BYTES_LIMIT) ? ROW_BYTES_LIMIT : tail_byte + 1;
        lead      = (reg_first_bit > 4'd8) ? 4'd8 : reg_first_bit;
        tail_mask = 16'hff00 >> reg_end_bit[2:0];
        bits      = src;
        if (byte_pos == 0)
            bits = bits & (8'hff >> lead);
        if (byte_pos == tail_byte)
            bits = bits & tail_mask[7:0];
        if (reg_bpp >= 3'd1 && reg_bpp <= 3'd4)
        begin
            colour = reg_colour & (32'hffff_ffff >> (32 - 8 * reg_bpp));
            for (int b = 0; b < 8; b++)
            begin
                if (bits[7 - b])
                begin
                    rest     = bits << (b + 1);
                    w.addr   = row_addr + (byte_pos * 8 + b) * reg_bpp;
                    w.colour = colour;
                    w.size   = reg_bpp;
                    w.last   = (rest == 8'h00);
                    pending_writes.push_back(w);
                end
            end
        end
        byte_pos = byte_pos + 1'b1;
        if (byte_pos >= span)
        begin
            byte_pos  = '0;
            rows_done = rows_done + 1'b1;
            row_addr  = row_addr + reg_stride;
        end
    endtask

    task automatic send_word(input logic [7:0] value);
        @(negedge clk);
        in_valid <= 1'b1;
        src_bits <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expand_word(value);
        while ($urandom_range(99) < src_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic wait_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_reg(idx, data);
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // program all registers; narrow ones get random junk above their width
    task automatic program_blit(input logic [31:0] base, input logic [15:0] stride,
                                input logic [3:0] first_bit, input logic [7:0] end_bit,
                                input logic [15:0] rows, input logic [2:0] bpp,
                                input logic [31:0] colour);
        settle();
        write_reg(mbce_pkg::CFG_DST_BASE, base);
        write_reg(mbce_pkg::CFG_DST_ROW_STRIDE, {16'($urandom_range(16'hffff)), stride});
        write_reg(mbce_pkg::CFG_FIRST_BIT, ($urandom << 4) | first_bit);
        write_reg(mbce_pkg::CFG_END_BIT_POS, ($urandom << 8) | end_bit);
        write_reg(mbce_pkg::CFG_ROW_COUNT, {16'($urandom_range(16'hffff)), rows});
        write_reg(mbce_pkg::CFG_BYTES_PER_PIXEL, ($urandom << 3) | bpp);
        write_reg(mbce_pkg::CFG_FILL_COLOUR, colour);
        end_writes();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        pixel_write_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_writes.size() == 0)
            begin
                $display("%0t: unexpected write, expected none, actual addr %h colour %h",
                         $time, write_addr, write_colour);
                fail_count++;
            end
            else
            begin
                want = pending_writes.pop_front();
                check_field("write_addr", want.addr, write_addr);
                check_field("write_colour", want.colour, write_colour);
                check_field("write_size", 32'(want.size), 32'(write_size));
                check_field("last_of_byte", 32'(want.last), 32'(last_of_byte));
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    task automatic test_edge_masks();
        program_blit(32'h0000_1000, 16'h0040, 4'd3, 8'd21, 16'd2, 3'd1, 32'h1234_56a5);
        send_word(8'hff);
        send_word(8'hff);
        send_word(8'hff);
        send_word(8'hff);
        send_word(8'h00);
        send_word(8'h81);
        send_word(8'hff);
    endtask

    task automatic test_single_byte_rows();
        program_blit(32'h0000_8000, 16'hffff, 4'd1, 8'd5, 16'd2, 3'd3, 32'hdead_beef);
        send_word(8'hff);
        send_word(8'haa);
        send_word(8'hff);
    endtask

    task automatic test_first_bit_overflow();
        program_blit(32'h0000_0100, 16'h0010, 4'd15, 8'd15, 16'd1, 3'd2, 32'hcafe_f00d);
        send_word(8'hff);
        send_word(8'hff);
        program_blit(32'h0000_0200, 16'h0010, 4'd8, 8'd7, 16'd1, 3'd1, 32'h0000_00ff);
        send_word(8'hff);
    endtask

    task automatic test_bad_pixel_size();
        program_blit(32'h0000_0400, 16'h0020, 4'd0, 8'd7, 16'd2, 3'd0, 32'hffff_ffff);
        send_word(8'hff);
        program_blit(32'h0000_0400, 16'h0020, 4'd0, 8'd7, 16'd2, 3'd5, 32'hffff_ffff);
        send_word(8'hff);
        program_blit(32'h0000_0400, 16'h0020, 4'd0, 8'd15, 16'd2, 3'd7, 32'hffff_ffff);
        send_word(8'hff);
        send_word(8'hff);
    endtask

    task automatic test_zero_rows();
        program_blit(32'h0000_0800, 16'h0020, 4'd0, 8'd7, 16'd0, 3'd4, 32'h0bad_cafe);
        send_word(8'hff);
        send_word(8'h55);
    endtask

    task automatic test_address_wrap();
        program_blit(32'hffff_fff8, 16'hffff, 4'd0, 8'd15, 16'd2, 3'd4, 32'hffff_ffff);
        send_word(8'hff);
        send_word(8'h01);
        send_word(8'h80);
        send_word(8'h00);
    endtask

    // a register write in the middle of a row restarts the blit; the spare index does not
    task automatic test_restart();
        program_blit(32'h0001_0000, 16'h0100, 4'd2, 8'd15, 16'd3, 3'd2, 32'h0000_abcd);
        send_word(8'hff);
        send_word(8'h3c);
        send_word(8'hf0);
        settle();
        write_reg(mbce_pkg::CFG_FILL_COLOUR, 32'h5a5a_1234);
        end_writes();
        send_word(8'hff);
        send_word(8'h0f);
        settle();
        write_reg(CFG_SPARE_INDEX, $urandom);
        end_writes();
        send_word(8'hff);
        send_word(8'hff);
    endtask

    task automatic run_random_blits(input int unsigned quota, input int unsigned src_pct,
                                    input int unsigned sink_pct);
        int unsigned sent;
        int unsigned end_bit;
        int unsigned first_bit;
        int unsigned rows;
        int unsigned span;
        int unsigned feed_rows;
        int unsigned pick;
        logic [2:0]  bpp;
        sent = 0;
        settle();
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        while (sent < quota)
        begin
            end_bit   = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(31);
            first_bit = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(8);
            rows      = ($urandom_range(15) == 0) ? 16'hffff : $urandom_range(4, 1);
            pick      = $urandom_range(3);
            if ($urandom_range(9) == 0)
                bpp = (pick == 0) ? 3'd0 : 3'(pick + 4);
            else
                bpp = 3'($urandom_range(4, 1));
            program_blit($urandom, 16'($urandom_range(16'hffff)), 4'(first_bit), 8'(end_bit),
                         16'(rows), bpp, $urandom);
            span = end_bit / 8 + 1;
            if (span > ROW_BYTES_LIMIT)
                span = ROW_BYTES_LIMIT;
            feed_rows = (rows > 4) ? $urandom_range(3, 1) : rows;
            if (span > 4)
                feed_rows = 1;
            repeat (feed_rows * span)
            begin
                send_word(8'($urandom_range(255)));
                sent++;
            end
            if (rows <= 4 && $urandom_range(4) == 0)
                repeat ($urandom_range(2, 1)) send_word(8'($urandom_range(255)));
        end
    endtask

    // long output hold-off fills the block; the sender also pauses for a full drain
    task automatic test_output_holdoff();
        settle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        program_blit($urandom, 16'($urandom_range(16'hffff)), 4'd0, 8'd31, 16'd2,
                     3'($urandom_range(4, 1)), $urandom);
        @(posedge clk);
        hold_request = 150;
        repeat (16) send_word(8'($urandom_range(255) | $urandom_range(255)));
        wait_results();
        repeat (16) send_word(8'($urandom_range(255) | $urandom_range(255)));
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        src_bits       = '0;
        out_stall      = 1'b0;
        fail_count     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_request   = 0;
        hold_left      = 0;
        reg_base       = '0;
        reg_stride     = '0;
        reg_first_bit  = '0;
        reg_end_bit    = '0;
        reg_rows       = '0;
        reg_bpp        = 3'd1;
        reg_colour     = '0;
        restart_blit();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_edge_masks();
        test_single_byte_rows();
        test_first_bit_overflow();
        test_bad_pixel_size();
        test_zero_rows();
        test_address_wrap();
        test_restart();
        run_random_blits(45, 0, 0);
        run_random_blits(45, 52, 0);
        run_random_blits(45, 0, 52);
        run_random_blits(45, 11, 11);
        test_output_holdoff();

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_writes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
